[sv/ssm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the sublist stream matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int VALUE_W         = 32;
	localparam int POS_W           = 4;
	localparam int LEN_W           = 5;
	localparam int OP_W            = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ELEM  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		logic             elem;
		logic             load;
		logic             clear;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} cell_ctrl_t;

endpackage

[sv/sublist_stream_matcher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sublist_stream_matcher_core
// Exact contiguous pattern match over a stream of signed 32-bit values.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns its result in the next cycle from
// an output register, so requests stream at one per cycle while out_ready is
// high. The figure is set by the row of MAX_PATTERN cells: every cell compares
// its stored pattern entry with the incoming element in parallel and takes its
// neighbor's prefix bit in the same cycle. Opcode load writes a pattern entry,
// element matches, clear starts a new list. The user must write pattern_length
// via cfg only while no request is in flight (not enforced); zero acts as one,
// values above MAX_PATTERN saturate. Pattern entries must be loaded before use.
module sublist_stream_matcher_core #(
	parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssm_pkg::LEN_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ssm_pkg::OP_W-1:0]           opcode,
	input  logic signed [ssm_pkg::VALUE_W-1:0] value,
	input  logic [ssm_pkg::POS_W-1:0]          position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               match_here,
	output logic                               found
);

	localparam int LW = ssm_pkg::LEN_W;

	logic [LW-1:0]          len_q;
	logic [LW-1:0]          eff_len;
	logic                   seen_q;
	logic                   out_valid_q;
	logic                   match_q;
	logic                   found_q;
	logic                   accept;
	logic                   any_hit;
	ssm_pkg::cell_ctrl_t    ctrl;
	logic [MAX_PATTERN:0]   chain;
	logic [MAX_PATTERN-1:0] hits;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign match_here = match_q;
	assign found      = found_q;
	assign chain[0]   = 1'b1;
	assign any_hit    = |hits;

	always_comb begin
		eff_len = len_q;
		if (len_q == '0) begin
			eff_len = LW'(1);
		end else if (int'(len_q) > MAX_PATTERN) begin
			eff_len = LW'(MAX_PATTERN);
		end
	end

	always_comb begin
		ctrl.elem  = accept && (opcode == ssm_pkg::OP_ELEM);
		ctrl.load  = accept && (opcode == ssm_pkg::OP_LOAD);
		ctrl.clear = accept && (opcode == ssm_pkg::OP_CLEAR);
		ctrl.pos   = position;
		ctrl.len   = eff_len;
	end

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		ssm_cell #(
			.IDX(k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.value        (value),
			.prev_partial (chain[k]),
			.partial_o    (chain[k+1]),
			.hit          (hits[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(1);
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.elem) begin
				seen_q <= seen_q || any_hit;
			end else if (ctrl.clear) begin
				seen_q <= 1'b0;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_q <= ctrl.elem && any_hit;
			if (ctrl.elem) begin
				found_q <= seen_q || any_hit;
			end else if (ctrl.clear) begin
				found_q <= 1'b0;
			end else begin
				found_q <= seen_q;
			end
		end
	end

endmodule

[sv/ssm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_cell
// One pattern entry with its prefix-match bit; takes the neighbor's bit.
// ----------------------------------------------------------------------------
module ssm_cell #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssm_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [ssm_pkg::VALUE_W-1:0]  value,
	input  logic                                prev_partial,
	output logic                                partial_o,
	output logic                                hit
);

	logic signed [ssm_pkg::VALUE_W-1:0] pat_q;
	logic                               partial_q;
	logic                               active;
	logic                               last;
	logic                               new_bit;

	always_comb begin
		active    = int'(ctrl.len) > IDX;
		last      = int'(ctrl.len) == IDX + 1;
		new_bit   = active && (pat_q == value) && prev_partial;
		hit       = new_bit && last;
		partial_o = partial_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && (int'(ctrl.pos) == IDX)) begin
			pat_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 1'b0;
		end else if (ctrl.elem) begin
			partial_q <= new_bit;
		end else if (ctrl.clear) begin
			partial_q <= 1'b0;
		end
	end

endmodule

[sv/ssm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks for the sublist stream matcher, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [ssm_pkg::OP_W-1:0]  opcode,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      match_here,
	input logic                      found
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_here) && $stable(found))
		else $error("result changed while stalled");

	a_match_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_here |-> found)
		else $error("match without found");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == ssm_pkg::OP_CLEAR)
		|=> out_valid && !found && !match_here)
		else $error("clear result not zero");

	a_non_elem: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode != ssm_pkg::OP_ELEM) |=> out_valid && !match_here)
		else $error("match on a non-element request");

endmodule

bind sublist_stream_matcher_core ssm_checker u_ssm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.opcode     (opcode),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.match_here (match_here),
	.found      (found)
);
